// ===== hw/rtl/wmfg_pkg.sv =====
package wmfg_pkg;

    // Build-time defaults for the top-level parameters
    localparam int TOTAL_BITS_DEF = 48;
    localparam int VFRAC_BITS_DEF = 16;

    // Field widths
    localparam int OP_W        = 3;
    localparam int CNT_W       = 32;
    localparam int MV_W        = 16;
    localparam int KQ_W        = 18;
    localparam int FLOW_W      = 32;
    localparam int TOTAL_OUT_W = 48;
    localparam int TANK_W      = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Fixed-point scaling
    localparam int KQ_FRAC_BITS    = 8;   // meter constant is Q.8
    localparam int FLOW_SCALE_BITS = 24;  // 2^24 = Q16 output times the Q.8 divisor
    localparam int FLOW_Q_BITS     = 27;  // Q24 quotients at or above 2^27 saturate flow
    localparam int FRAC_STEPS      = 6;   // quotient bits of 60*r/k, always below 64
    localparam int TANK_SHIFT      = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_TAMPER = 3'd3;
    localparam logic [OP_W-1:0] OP_FREEZE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PPL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

    // Constants
    localparam logic [KQ_W-1:0]   PPL_RESET    = 18'd512;
    localparam logic [FLOW_W-1:0] BURST_RESET  = 32'd2621440;
    localparam logic [KQ_W-1:0]   K_MIN        = 18'd3;
    localparam logic [FLOW_W-1:0] LEAK_THRESH  = 32'd6554;
    localparam logic [TANK_W-1:0] TANK_FULL    = 15'd25600;
    localparam int                TDEN_W       = 6;
    localparam logic [TDEN_W-1:0] TANK_DIVISOR = 6'd33;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [CNT_W-1:0]       pulse_count;
        logic signed [MV_W-1:0] tank_millivolts;
        logic                   freeze_value;
    } t_in_item;

    typedef struct packed {
        logic [FLOW_W-1:0]      flow_rate;
        logic [TOTAL_OUT_W-1:0] total_volume;
        logic [TANK_W-1:0]      tank_percent;
        logic                   valve_is_open;
        logic                   leak_flag;
        logic                   burst_flag;
        logic                   tamper_flag;
        logic                   billing_frozen;
        logic                   alarm;
        logic                   status;
    } t_result;

endpackage

// ===== hw/rtl/wmfg_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Numerator and quotient share one shift register.
module wmfg_sdiv #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    output logic                           o_busy,
    output logic [$clog2(NUM_W+1)-1:0]     o_steps,
    output logic [NUM_W-1:0]               o_quot,
    output logic [DEN_W-1:0]               o_rem
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;

    logic [DEN_W:0] partial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        partial = {r_rem, r_nq[NUM_W-1]};
        diff    = partial - {1'b0, r_den};
        fits    = (partial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= '0;
        end else if (r_busy) begin
            r_steps <= r_steps + 1'b1;
            if (r_steps == STEP_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // shift in the new quotient bit, keep the partial remainder below the divisor
            r_nq  <= {r_nq[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
        end
    end

    assign o_busy  = r_busy;
    assign o_steps = r_steps;
    assign o_quot  = r_nq;
    assign o_rem   = r_rem;

endmodule

// ===== hw/rtl/water_meter_flow_guard_core.sv =====
// Water meter flow guard.
// Input channel: i_in_data (operation, pulse count, tank voltage, freeze value) moves on a
// transfer when i_in_valid is high and o_in_stall is low. Output channel: o_out_data moves
// when o_out_valid is high and i_out_stall is low; every input item yields one result.
// Configuration: i_cfg_index / i_cfg_data are written on i_cfg_valid (o_cfg_ready is always
// high); index 0 is the meter constant, index 1 the burst limit, other indexes are ignored.
// Write configuration only while no item is in flight.
// Timing: a command item goes from its transfer to the write-back state, then into the
// output register once that is free. A sample runs a bit-serial divide of the count
// delta by the meter constant, one bit per cycle over 32 + max(24, 8 + VOLUME_FRAC_BITS)
// bits, then leaves the divide, loads the fraction, runs six fraction steps for the flow,
// computes flow and volume and goes to write-back. The block works on one item at a time;
// o_in_stall is high from the transfer until the result is written into the output
// register, so no new item is taken before the last one is written.
// The output register decouples the sides: a new item is taken while the last result still
// waits; when the receiver stalls, the result holds and a finished item waits to be written.
// Reset (synchronous, active low) loads the register defaults, clears all totals and flags
// and opens the valve.
module water_meter_flow_guard_core
    import wmfg_pkg::*;
#(
    parameter int TOTAL_BITS       = TOTAL_BITS_DEF,
    parameter int VOLUME_FRAC_BITS = VFRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output t_result               o_out_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Fraction bits carried by the divider: enough for both flow (Q24) and litres.
    localparam int LIT_FRAC   = KQ_FRAC_BITS + VOLUME_FRAC_BITS;
    localparam int DIV_FRAC   = (LIT_FRAC > FLOW_SCALE_BITS) ? LIT_FRAC : FLOW_SCALE_BITS;
    localparam int NUM_W      = CNT_W + DIV_FRAC;
    localparam int STEP_W     = $clog2(NUM_W + 1);
    localparam int Q24_W      = CNT_W + FLOW_SCALE_BITS;
    localparam int LIT_SHIFT  = DIV_FRAC - LIT_FRAC;
    localparam int LIT_W      = CNT_W + LIT_FRAC;
    localparam int SUM_W      = ((TOTAL_BITS > LIT_W) ? TOTAL_BITS : LIT_W) + 1;
    localparam int TNUM_W     = MV_W - 1 + TANK_SHIFT;
    localparam int FR_W       = KQ_W + FRAC_STEPS;
    localparam int FCNT_W     = $clog2(FRAC_STEPS);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FRLD,
        S_FRAC,
        S_FLOW,
        S_WB
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [KQ_W-1:0]   r_ppl;
    logic [FLOW_W-1:0] r_burst_lim;

    // Architectural state
    logic [CNT_W-1:0]      r_prev;
    logic [FLOW_W-1:0]     r_flow;
    logic [TOTAL_BITS-1:0] r_vol;
    logic [TANK_W-1:0]     r_tank;
    logic                  r_valve;
    logic                  r_leak;
    logic                  r_burst;
    logic                  r_tamper;
    logic                  r_freeze;

    // Item in flight
    logic [OP_W-1:0]  r_op;
    logic [CNT_W-1:0] r_cnt;
    logic             r_frz;
    logic             r_tank_upd;
    logic             r_k_ok;

    // Sample datapath
    logic [Q24_W-1:0]      r_q24;
    logic [KQ_W-1:0]       r_r24;
    logic [LIT_W-1:0]      r_litres;
    logic [TANK_W-1:0]     r_pct;
    logic [FR_W-1:0]       r_fr;
    logic [FR_W-1:0]       r_kd;
    logic [FRAC_STEPS-1:0] r_fq;
    logic [FCNT_W-1:0]     r_fcnt;
    logic [FLOW_W-1:0]     r_flow_new;
    logic [TOTAL_BITS-1:0] r_vol_new;

    // Output register
    t_result r_out;
    logic    r_out_valid;

    logic              accept;
    logic              div_start;
    logic              wb_go;
    logic [CNT_W-1:0]  delta;
    logic              main_busy;
    logic [STEP_W-1:0] main_steps;
    logic [NUM_W-1:0]  main_quot;
    logic [KQ_W-1:0]   main_rem;
    logic              tank_busy;
    logic [TNUM_W-1:0] tank_quot;

    logic [FLOW_Q_BITS-1:0]   q_lo;
    logic [FLOW_Q_BITS+5:0]   flow_full;
    logic [FLOW_W-1:0]        flow_calc;
    logic [LIT_W-1:0]         lit_eff;
    logic [SUM_W-1:0]         vol_sum;
    logic [TOTAL_BITS-1:0]    vol_calc;

    logic [CNT_W-1:0]      n_prev;
    logic [FLOW_W-1:0]     n_flow;
    logic [TOTAL_BITS-1:0] n_vol;
    logic [TANK_W-1:0]     n_tank;
    logic                  n_valve;
    logic                  n_leak;
    logic                  n_burst;
    logic                  n_tamper;
    logic                  n_freeze;
    logic                  n_status;
    t_result               n_result;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign div_start  = accept && (i_in_data.operation == OP_SAMPLE);
    assign wb_go      = (r_state == S_WB) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

    // Count delta; a counter that went backwards counts as no flow
    assign delta = (i_in_data.pulse_count >= r_prev) ? (i_in_data.pulse_count - r_prev) : '0;

    // Main divider: (delta << DIV_FRAC) / meter constant
    wmfg_sdiv #(
        .NUM_W (NUM_W),
        .DEN_W (KQ_W)
    ) u_div_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({delta, {DIV_FRAC{1'b0}}}),
        .i_den   (r_ppl),
        .o_busy  (main_busy),
        .o_steps (main_steps),
        .o_quot  (main_quot),
        .o_rem   (main_rem)
    );

    // Tank divider: (millivolts << 8) / 33, runs alongside and finishes first
    wmfg_sdiv #(
        .NUM_W (TNUM_W),
        .DEN_W (TDEN_W)
    ) u_div_tank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({i_in_data.tank_millivolts[MV_W-2:0], {TANK_SHIFT{1'b0}}}),
        .i_den   (TANK_DIVISOR),
        .o_busy  (tank_busy),
        .o_steps (),
        .o_quot  (tank_quot),
        .o_rem   ()
    );

    // Flow = 60 * Q24 + floor(60 * r24 / k); the fraction term sits in the low six bits
    always_comb begin
        q_lo      = r_q24[FLOW_Q_BITS-1:0];
        flow_full = {q_lo, r_fq} - (FLOW_Q_BITS+6)'({q_lo, 2'b00});
        if (!r_k_ok) begin
            flow_calc = '0;
        end else if ((|r_q24[Q24_W-1:FLOW_Q_BITS]) || flow_full[FLOW_Q_BITS+5:FLOW_W] != '0) begin
            flow_calc = '1;
        end else begin
            flow_calc = flow_full[FLOW_W-1:0];
        end

        lit_eff  = r_k_ok ? r_litres : '0;
        vol_sum  = SUM_W'(r_vol) + SUM_W'(lit_eff);
        vol_calc = (vol_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : vol_sum[TOTAL_BITS-1:0];
    end

    // State after the item in flight
    always_comb begin
        n_prev   = r_prev;
        n_flow   = r_flow;
        n_vol    = r_vol;
        n_tank   = r_tank;
        n_valve  = r_valve;
        n_leak   = r_leak;
        n_burst  = r_burst;
        n_tamper = r_tamper;
        n_freeze = r_freeze;
        n_status = 1'b0;
        unique case (r_op)
            OP_SAMPLE: begin
                n_prev = r_cnt;
                n_flow = r_flow_new;
                if (!r_freeze) begin
                    n_vol = r_vol_new;
                end
                if (r_tank_upd) begin
                    n_tank = r_pct;
                end
                // leak looks at the valve before this sample's burst check
                n_leak  = (r_flow_new >= LEAK_THRESH) && !r_valve;
                n_burst = (r_flow_new > r_burst_lim);
                if (n_burst) begin
                    n_valve = 1'b0;
                end
            end
            OP_OPEN: begin
                if (r_tamper) begin
                    n_status = 1'b1;
                end else begin
                    n_valve = 1'b1;
                end
            end
            OP_CLOSE: begin
                n_valve = 1'b0;
            end
            OP_TAMPER: begin
                n_tamper = 1'b1;
                n_valve  = 1'b0;
            end
            OP_FREEZE: begin
                n_freeze = r_frz;
            end
            default: begin
            end
        endcase

        n_result.flow_rate      = n_flow;
        n_result.total_volume   = TOTAL_OUT_W'(n_vol);
        n_result.tank_percent   = n_tank;
        n_result.valve_is_open  = n_valve;
        n_result.leak_flag      = n_leak;
        n_result.burst_flag     = n_burst;
        n_result.tamper_flag    = n_tamper;
        n_result.billing_frozen = n_freeze;
        n_result.alarm          = n_leak || n_burst || n_tamper;
        n_result.status         = n_status;
    end

    // Sequencer, architectural state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ppl       <= PPL_RESET;
            r_burst_lim <= BURST_RESET;
            r_prev      <= '0;
            r_flow      <= '0;
            r_vol       <= '0;
            r_tank      <= '0;
            r_valve     <= 1'b1;
            r_leak      <= 1'b0;
            r_burst     <= 1'b0;
            r_tamper    <= 1'b0;
            r_freeze    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PPL:   r_ppl       <= i_cfg_data[KQ_W-1:0];
                    CFG_BURST: r_burst_lim <= i_cfg_data[FLOW_W-1:0];
                    default: begin
                    end
                endcase
            end

            // raise the valid when a result is written, drop it once the receiver takes it
            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_in_data.operation == OP_SAMPLE) ? S_DIV : S_WB;
                    end
                end
                S_DIV: begin
                    if (!main_busy && !tank_busy) begin
                        r_state <= S_FRLD;
                    end
                end
                S_FRLD: begin
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    if (r_fcnt == FCNT_W'(FRAC_STEPS - 1)) begin
                        r_state <= S_FLOW;
                    end
                end
                S_FLOW: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_go) begin
                        r_state     <= S_IDLE;
                        r_out       <= n_result;
                        r_prev      <= n_prev;
                        r_flow      <= n_flow;
                        r_vol       <= n_vol;
                        r_tank      <= n_tank;
                        r_valve     <= n_valve;
                        r_leak      <= n_leak;
                        r_burst     <= n_burst;
                        r_tamper    <= n_tamper;
                        r_freeze    <= n_freeze;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item and sample datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_in_data.operation;
            r_cnt      <= i_in_data.pulse_count;
            r_frz      <= i_in_data.freeze_value;
            r_tank_upd <= !i_in_data.tank_millivolts[MV_W-1] && (i_in_data.tank_millivolts != '0);
            r_k_ok     <= (r_ppl >= K_MIN);
        end

        // Capture the Q24 quotient and remainder on the way through
        if (r_state == S_DIV && main_steps == STEP_W'(Q24_W)) begin
            r_q24 <= main_quot[Q24_W-1:0];
            r_r24 <= main_rem;
        end

        if (r_state == S_FRLD) begin
            r_fr     <= {r_r24, 6'b000000} - FR_W'({r_r24, 2'b00});
            r_kd     <= FR_W'({r_ppl, {(FRAC_STEPS-1){1'b0}}});
            r_fq     <= '0;
            r_fcnt   <= '0;
            r_litres <= main_quot[NUM_W-1:LIT_SHIFT];
            r_pct    <= (tank_quot > TNUM_W'(TANK_FULL)) ? TANK_FULL : tank_quot[TANK_W-1:0];
        end

        // One quotient bit of 60 * r24 / k per cycle
        if (r_state == S_FRAC) begin
            if (r_fr >= r_kd) begin
                r_fr <= r_fr - r_kd;
                r_fq <= {r_fq[FRAC_STEPS-2:0], 1'b1};
            end else begin
                r_fq <= {r_fq[FRAC_STEPS-2:0], 1'b0};
            end
            r_kd   <= r_kd >> 1;
            r_fcnt <= r_fcnt + 1'b1;
        end

        if (r_state == S_FLOW) begin
            r_flow_new <= flow_calc;
            r_vol_new  <= vol_calc;
        end
    end

endmodule

// ===== dv/water_meter_flow_guard_core_test.sv =====
module water_meter_flow_guard_core_test
    import wmfg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Clocking and run length
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_IDLE        = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;   // idle margin before a register write
    localparam int DRAIN_TAIL      = 80;  // idle margin after the last result before the run ends
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 55;

    // Operation codes the package leaves unnamed; the block treats them as no-ops
    localparam logic [OP_W-1:0] OP_UNDEF_MIN = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_MAX = 3'd7;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    // Arithmetic of the meter
    localparam logic [63:0] FLOW_PER_MIN = 64'd60;
    localparam logic [63:0] VOLUME_MAX   = (64'd1 << TOTAL_BITS_DEF) - 64'd1;
    localparam logic [63:0] FLOW_MAX     = 64'hFFFF_FFFF;

    // Readings that follow straight from the reset state
    localparam t_result AT_RESET = '{
        flow_rate: '0, total_volume: '0, tank_percent: '0, valve_is_open: 1'b1,
        leak_flag: 1'b0, burst_flag: 1'b0, tamper_flag: 1'b0, billing_frozen: 1'b0,
        alarm: 1'b0, status: 1'b0
    };
    // 1000 pulses at 2 pulses per litre: 500 l, 30000 l/min, far above the 40 l/min limit
    localparam t_result FIRST_BURST = '{
        flow_rate: 32'd1966080000, total_volume: 48'd32768000, tank_percent: 15'd25600,
        valve_is_open: 1'b0, leak_flag: 1'b0, burst_flag: 1'b1, tamper_flag: 1'b0,
        billing_frozen: 1'b0, alarm: 1'b1, status: 1'b0
    };

    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  want;
    } t_meter_row;

    localparam int HEAD_ROWS  = 20;
    localparam int TOTAL_ROWS = 25;

    // Directed script. The head runs at the reset register values; the tail latches
    // tamper, which nothing but reset clears, so it runs after the random part.
    t_meter_row script [TOTAL_ROWS] = '{
        '{'{OP_UNDEF_MAX, 32'hFFFF_FFFF, -16'sd1,     1'b1}, 1'b1, AT_RESET},
        '{'{OP_SAMPLE,    32'd0,         16'sd0,      1'b0}, 1'b1, AT_RESET},
        '{'{OP_SAMPLE,    32'd1000,      16'sd3300,   1'b0}, 1'b1, FIRST_BURST},
        '{'{OP_SAMPLE,    32'd500,       16'sh8000,   1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd510,       16'sd1,      1'b0}, 1'b0, '0},
        '{'{OP_OPEN,      32'hFFFF_FFFF, 16'sd32767,  1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd512,       16'sd33,     1'b0}, 1'b0, '0},
        '{'{OP_OPEN,      32'd0,         16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd513,       16'sd100,    1'b0}, 1'b0, '0},
        '{'{OP_CLOSE,     32'h1234_5678, -16'sd5,     1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd514,       16'sd200,    1'b0}, 1'b0, '0},
        '{'{OP_FREEZE,    32'd0,         16'sd0,      1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd1514,      16'sd32767,  1'b0}, 1'b0, '0},
        '{'{OP_FREEZE,    32'hFFFF_FFFF, -16'sd1,     1'b0}, 1'b0, '0},
        '{'{OP_OPEN,      32'd0,         16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'hFFFF_FFFF, 16'sd32767,  1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'hFFFF_FFFF, 16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd0,         16'sh8000,   1'b0}, 1'b0, '0},
        '{'{OP_UNDEF_MIN, 32'd0,         16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd1000,      16'sd1650,   1'b0}, 1'b0, '0},
        '{'{OP_TAMPER,    32'hA5A5_5A5A, 16'sd1234,   1'b1}, 1'b0, '0},
        '{'{OP_OPEN,      32'd0,         16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE,    32'd0,         16'sd3300,   1'b0}, 1'b0, '0},
        '{'{OP_CLOSE,     32'd0,         16'sd0,      1'b0}, 1'b0, '0},
        '{'{OP_OPEN,      32'hFFFF_FFFF, -16'sd1,     1'b1}, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    t_in_item              i_in_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_result               o_out_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Meter state as the testbench tracks it, starting from the reset values
    logic [KQ_W-1:0]   meter_k     = PPL_RESET;
    logic [FLOW_W-1:0] burst_limit = BURST_RESET;
    logic [CNT_W-1:0]  last_count  = '0;
    logic [FLOW_W-1:0] flow_now    = '0;
    logic [63:0]       volume_acc  = '0;
    logic [TANK_W-1:0] tank_now    = '0;
    logic              valve_now   = 1'b1;
    logic              leak_now    = 1'b0;
    logic              burst_now   = 1'b0;
    logic              tamper_now  = 1'b0;
    logic              frozen_now  = 1'b0;

    t_result expected_readings [$];
    t_result oldest_reading;
    int      error_count = 0;
    int      cycle_count;
    bit      sender_quiet   = 1'b0;
    bit      receiver_quiet = 1'b0;
    bit      hold_off_req   = 1'b0;

    water_meter_flow_guard_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Advance the tracked meter state by one item and return the reading it shows.
    function automatic t_result advance_meter(input t_in_item it);
        t_result     r;
        logic [63:0] delta;
        logic [63:0] litres;
        logic [63:0] flow;
        logic [31:0] pct;
        logic        denied;
        denied = 1'b0;
        case (it.operation)
            OP_SAMPLE: begin
                // a counter that went backwards counts as no flow
                delta = (it.pulse_count >= last_count) ? 64'(it.pulse_count - last_count)
                                                        : 64'd0;
                last_count = it.pulse_count;
                litres = '0;
                flow   = '0;
                // a meter constant of 0.01 or less yields nothing at all
                if (meter_k >= K_MIN) begin
                    litres = (delta << (KQ_FRAC_BITS + VFRAC_BITS_DEF)) / 64'(meter_k);
                    flow   = ((delta * FLOW_PER_MIN) << FLOW_SCALE_BITS) / 64'(meter_k);
                    if (flow > FLOW_MAX) begin
                        flow = FLOW_MAX;
                    end
                end
                flow_now = flow[FLOW_W-1:0];
                if (!frozen_now) begin
                    volume_acc = (litres > VOLUME_MAX - volume_acc) ? VOLUME_MAX
                                                                    : volume_acc + litres;
                end
                // only a positive voltage moves the tank level
                if (!it.tank_millivolts[MV_W-1] && it.tank_millivolts != '0) begin
                    pct = (32'(unsigned'(it.tank_millivolts)) << TANK_SHIFT) / 32'(TANK_DIVISOR);
                    tank_now = (pct > 32'(TANK_FULL)) ? TANK_FULL : pct[TANK_W-1:0];
                end
                // leak looks at the valve as it was before this sample's burst check
                leak_now  = (flow_now >= LEAK_THRESH) && !valve_now;
                burst_now = flow_now > burst_limit;
                if (burst_now) begin
                    valve_now = 1'b0;
                end
            end
            OP_OPEN: begin
                if (tamper_now) begin
                    denied = 1'b1;
                end else begin
                    valve_now = 1'b1;
                end
            end
            OP_CLOSE: begin
                valve_now = 1'b0;
            end
            OP_TAMPER: begin
                tamper_now = 1'b1;
                valve_now  = 1'b0;
            end
            OP_FREEZE: begin
                frozen_now = it.freeze_value;
            end
            default: begin
            end
        endcase
        r.flow_rate      = flow_now;
        r.total_volume   = volume_acc[TOTAL_OUT_W-1:0];
        r.tank_percent   = tank_now;
        r.valve_is_open  = valve_now;
        r.leak_flag      = leak_now;
        r.burst_flag     = burst_now;
        r.tamper_flag    = tamper_now;
        r.billing_frozen = frozen_now;
        r.alarm          = leak_now || burst_now || tamper_now;
        r.status         = denied;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        end
    endtask

    // Offer one item after a random gap, hold it until the block takes it, then
    // queue the reading it should produce. Called and returns at a falling edge.
    task automatic send_item(input t_in_item it, input bit typed, input t_result want);
        int unsigned gap;
        t_result     predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        predicted = advance_meter(it);
        expected_readings.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every queued reading has come back.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Present one register write; the caller drops valid after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PPL:   meter_k     = data[KQ_W-1:0];
            CFG_BURST: burst_limit = data;
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    // Check every result transfer against the oldest queued reading.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("result with none expected: 0x%0h", o_out_data);
                end
            end else begin
                oldest_reading = expected_readings.pop_front();
                check_field("flow_rate", 64'(oldest_reading.flow_rate),
                            64'(o_out_data.flow_rate));
                check_field("total_volume", 64'(oldest_reading.total_volume),
                            64'(o_out_data.total_volume));
                check_field("tank_percent", 64'(oldest_reading.tank_percent),
                            64'(o_out_data.tank_percent));
                check_field("valve_is_open", 64'(oldest_reading.valve_is_open),
                            64'(o_out_data.valve_is_open));
                check_field("leak_flag", 64'(oldest_reading.leak_flag),
                            64'(o_out_data.leak_flag));
                check_field("burst_flag", 64'(oldest_reading.burst_flag),
                            64'(o_out_data.burst_flag));
                check_field("tamper_flag", 64'(oldest_reading.tamper_flag),
                            64'(o_out_data.tamper_flag));
                check_field("billing_frozen", 64'(oldest_reading.billing_frozen),
                            64'(o_out_data.billing_frozen));
                check_field("alarm", 64'(oldest_reading.alarm), 64'(o_out_data.alarm));
                check_field("status", 64'(oldest_reading.status), 64'(o_out_data.status));
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer, or one long
    // stretch when asked, so that the block backs up into its input.
    initial begin
        int unsigned stall_len;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall_len = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_off_req) begin
                stall_len    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** water_meter_flow_guard_core: FAILED **");
        $finish;
    end

    initial begin
        t_in_item        it;
        int unsigned     roll;
        logic [KQ_W-1:0] k;
        logic [31:0]     limit_q16;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed head at the reset register values
        for (int r = 0; r < HEAD_ROWS; r++) begin
            send_item(script[r].item, script[r].typed, script[r].want);
        end
        wait_until_drained();

        // Random part, one register setting per phase, extremes first
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    k = PPL_RESET;
                    limit_q16 = BURST_RESET;
                end
                1: begin
                    k = 18'd26;
                    limit_q16 = '0;
                end
                2: begin
                    k = 18'd256000;
                    limit_q16 = '1;
                end
                3: begin
                    k = K_MIN;
                    limit_q16 = LEAK_THRESH;
                end
                4: begin
                    k = 18'd2;
                    limit_q16 = $urandom;
                end
                5: begin
                    k = '0;
                    limit_q16 = $urandom;
                end
                6: begin
                    k = '1;
                    limit_q16 = $urandom;
                end
                default: begin
                    k = KQ_W'($urandom_range(26, 256000));
                    limit_q16 = $urandom_range(0, 4 * BURST_RESET);
                end
            endcase
            // garbage above the meter constant must be dropped by the block
            write_register(CFG_PPL, ($urandom & ~32'(18'h3FFFF)) | 32'(k));
            write_register(CFG_BURST, limit_q16);
            write_register(phase[0] ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
            i_cfg_valid <= 1'b0;

            // keep phase 2 free of idle cycles on both sides, other phases on either side at random
            sender_quiet   = (phase == 2) || ($urandom_range(0, 4) == 0);
            receiver_quiet = (phase == 2) || ($urandom_range(0, 4) == 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ((phase == 3 || phase == 7) && n == 10) begin
                    hold_off_req = 1'b1;
                end
                if (phase == 5 && n == 25) begin
                    wait_until_drained();
                end
                // fields a command ignores still carry noise
                it.pulse_count     = $urandom;
                it.tank_millivolts = MV_W'($urandom);
                it.freeze_value    = 1'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    it.operation = OP_SAMPLE;
                    case ($urandom_range(0, 9))
                        0: it.pulse_count = $urandom;
                        1: it.pulse_count = last_count + $urandom_range(0, 1 << 20);
                        2, 3, 4: it.pulse_count = last_count + $urandom_range(0, 4000);
                        default: it.pulse_count = last_count + $urandom_range(0, 40);
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1: it.tank_millivolts = MV_W'($urandom_range(1, 3400));
                        2: it.tank_millivolts = MV_W'($urandom);
                        default: it.tank_millivolts = '0;
                    endcase
                end else if (roll < 80) begin
                    it.operation = OP_OPEN;
                end else if (roll < 87) begin
                    it.operation = OP_CLOSE;
                end else if (roll < 95) begin
                    it.operation = OP_FREEZE;
                end else begin
                    it.operation = OP_W'($urandom_range(32'(OP_UNDEF_MIN), 32'(OP_UNDEF_MAX)));
                end
                send_item(it, 1'b0, '0);
            end
            wait_until_drained();
        end

        // Directed tail: tamper and the denied open that follows it
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        for (int r = HEAD_ROWS; r < TOTAL_ROWS; r++) begin
            send_item(script[r].item, script[r].typed, script[r].want);
        end
        wait_until_drained();
        repeat (DRAIN_TAIL) @(negedge i_clk);

        if (error_count == 0) begin
            $display("** water_meter_flow_guard_core: PASSED **");
        end else begin
            $display("** water_meter_flow_guard_core: FAILED **");
        end
        $finish;
    end

endmodule
